/* sv/ppt_pkg.sv */
// Shared types for the pin pattern trigger table: request and result records.
package ppt_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int TERMS_DEF     = 4;
    localparam int PORTS_DEF     = 6;
    localparam int PINS_DEF      = 4;

    localparam int SLOT_FIELD_W  = 4;
    localparam int TERM_W        = 7;
    localparam int MAX_TERMS     = 4;
    localparam int LEVELS_W      = 24;
    localparam int CNT_W         = 3;
    localparam int S_TDATA_W     = 64;
    localparam int M_TDATA_W     = 8;

    typedef enum logic {
        OP_PROGRAM = 1'b0,
        OP_CHECK   = 1'b1
    } op_t;

    typedef struct packed {
        op_t                                  operation;
        logic [SLOT_FIELD_W-1:0]              slot;
        logic                                 enable;
        logic [1:0]                           term_count_minus_one;
        logic [MAX_TERMS-1:0][TERM_W-1:0]     terms;
        logic [LEVELS_W-1:0]                  pin_levels;
    } ppt_req_t;

    typedef struct packed {
        logic triggered;
        logic slot_enabled;
    } ppt_res_t;

endpackage

/* sv/ppt_table.sv */
// Trigger descriptor storage with its program path and the parallel term match.
module ppt_table import ppt_pkg::*; #(
    parameter int SLOTS         = SLOTS_DEF,
    parameter int TERMS         = TERMS_DEF,
    parameter int PORTS         = PORTS_DEF,
    parameter int PINS_PER_PORT = PINS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  ppt_req_t req,
    input  logic     step,
    output ppt_res_t res
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_FIELD_W:0] SLOTS_C = (SLOT_FIELD_W + 1)'(SLOTS);
    localparam logic [CNT_W-1:0]      TERMS_C = CNT_W'(TERMS);
    localparam logic [3:0]            PORTS_C = 4'(PORTS);
    localparam logic [3:0]            PINS_C  = 4'(PINS_PER_PORT);
    localparam logic [5:0]            PINS_M  = 6'(PINS_PER_PORT);
    localparam logic [5:0]            LVL_C   = 6'(LEVELS_W);

    logic [SLOTS-1:0]                        en_reg;
    logic [SLOTS-1:0][CNT_W-1:0]             cnt_reg;
    logic [SLOTS-1:0][TERMS-1:0][TERM_W-1:0] word_reg;

    logic                     in_range;
    logic [SLOT_W-1:0]        idx;
    logic [CNT_W-1:0]         cnt_raw;
    logic [CNT_W-1:0]         cnt_sat;
    logic                     do_write;
    logic                     rd_en;
    logic [CNT_W-1:0]         rd_cnt;
    logic                     all_match;

    // Level of the pin a term names; positions off the port grid read as low.
    function automatic logic term_level(input logic [TERM_W-1:0] term,
                                        input logic [LEVELS_W-1:0] levels);
        logic [2:0] port;
        logic [2:0] pin;
        logic [5:0] pos;
        port = term[2:0];
        pin  = term[5:3];
        pos  = {3'b000, port} * PINS_M + {3'b000, pin};
        if (({1'b0, port} >= PORTS_C) || ({1'b0, pin} >= PINS_C) || (pos >= LVL_C)) begin
            term_level = 1'b0;
        end else begin
            term_level = levels[pos[4:0]];
        end
    endfunction

    assign in_range = {1'b0, req.slot} < SLOTS_C;
    assign idx      = req.slot[SLOT_W-1:0];
    assign cnt_raw  = {1'b0, req.term_count_minus_one} + CNT_W'(1);
    assign cnt_sat  = (cnt_raw > TERMS_C) ? TERMS_C : cnt_raw;
    assign do_write = step && in_range && (req.operation == OP_PROGRAM);

    assign rd_en  = en_reg[idx];
    assign rd_cnt = cnt_reg[idx];

    always_comb begin
        all_match = 1'b1;
        for (int k = 0; k < TERMS; k++) begin
            if ((CNT_W'(k) < rd_cnt) &&
                (term_level(word_reg[idx][k], req.pin_levels) != word_reg[idx][k][6])) begin
                all_match = 1'b0;
            end
        end
    end

    always_comb begin
        res.triggered    = in_range && (req.operation == OP_CHECK) && rd_en &&
                           (rd_cnt != '0) && all_match;
        res.slot_enabled = in_range &&
                           ((req.operation == OP_PROGRAM) ? req.enable : rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg  <= '0;
            cnt_reg <= '0;
        end else if (do_write) begin
            en_reg[idx]  <= req.enable;
            cnt_reg[idx] <= req.enable ? cnt_sat : '0;
        end
    end

    // Term words are only looked at below the stored count, so they need no reset.
    always_ff @(posedge aclk) begin
        if (do_write && req.enable) begin
            for (int k = 0; k < TERMS; k++) begin
                if (CNT_W'(k) < cnt_sat) begin
                    word_reg[idx][k] <= req.terms[k];
                end
            end
        end
    end

endmodule

/* sv/pin_pattern_trigger_table_core.sv */
// Top level of the pin pattern trigger table: stream ports, input and result registers.
// An accepted request waits in the input register; its result then moves into the
// result register behind m_tvalid. Throughput: one request per cycle unless m_tready
// stalls; descriptor read, the four term compares and descriptor write lie in between.
// A check right after a program of the same slot sees the new descriptor.
// Reset (aresetn low, synchronous) disables every slot and empties both registers.
module pin_pattern_trigger_table_core import ppt_pkg::*; #(
    parameter int SLOTS         = SLOTS_DEF,
    parameter int TERMS         = TERMS_DEF,
    parameter int PORTS         = PORTS_DEF,
    parameter int PINS_PER_PORT = PINS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0 up: slot[3:0], enable[4], term_count_minus_one[6:5],
    // term_a[13:7], term_b[20:14], term_c[27:21], term_d[34:28],
    // pin_levels[58:35], zero fill[63:59].
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Fields: operation[0] (0 program a slot, 1 check a slot).
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0 up: triggered[0], slot_enabled[1], zero fill[7:2].
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic     in_valid_reg;
    ppt_req_t in_req_reg;
    logic     out_valid_reg;
    ppt_res_t out_res_reg;

    ppt_req_t s_req;
    ppt_res_t table_res;
    logic     out_load;
    logic     step;

    // Unpack the incoming request into its fields.
    always_comb begin
        s_req.operation            = op_t'(s_tuser[0]);
        s_req.slot                 = s_tdata[3:0];
        s_req.enable               = s_tdata[4];
        s_req.term_count_minus_one = s_tdata[6:5];
        s_req.terms[0]             = s_tdata[13:7];
        s_req.terms[1]             = s_tdata[20:14];
        s_req.terms[2]             = s_tdata[27:21];
        s_req.terms[3]             = s_tdata[34:28];
        s_req.pin_levels           = s_tdata[58:35];
    end

    // The result register can take a new value when it is empty or being drained.
    // The held request moves on (and updates the table) exactly when that happens,
    // and the input register frees up in the same cycle.
    assign out_load = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg <= s_req;
        end
    end

    ppt_table #(
        .SLOTS         (SLOTS),
        .TERMS         (TERMS),
        .PORTS         (PORTS),
        .PINS_PER_PORT (PINS_PER_PORT)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (in_req_reg),
        .step    (step),
        .res     (table_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= table_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 2)'(0), out_res_reg.slot_enabled, out_res_reg.triggered};

    // A held request that cannot move on must stay in place.
    a_hold_request: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_load |=> in_valid_reg && $stable(in_req_reg))
        else $error("pending request lost or changed while stalled");

    // A program request never produces a trigger.
    a_program_no_trigger: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (in_req_reg.operation == OP_PROGRAM) |=> !out_res_reg.triggered)
        else $error("program request produced a trigger");

    // A trigger can only come from an enabled slot.
    a_trigger_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.triggered |-> out_res_reg.slot_enabled)
        else $error("trigger reported on a disabled slot");

    // Every request moved into the result register shows up as a valid result.
    a_step_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> out_valid_reg)
        else $error("result register did not capture a request");

endmodule
